// ===== design/smr_pkg.sv =====
`default_nettype none

package smr_pkg;

    localparam int MAX_BINS   = 1024;
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int COUNT_W    = BIN_W + 1;
    localparam int MAG_W      = 24;
    localparam int RES_W      = 25;
    localparam int DIFF_W     = 26;
    localparam int GAIN_W     = 16;
    localparam int DELAY_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_W     = 15;

    localparam logic [GAIN_W-1:0]  GAIN_ONE      = GAIN_W'(32768);
    localparam logic [DELAY_W-1:0] DELAY_RESET   = DELAY_W'(1);
    localparam logic [GAIN_W-1:0]  GAIN_RESET    = GAIN_W'(16384);
    localparam logic [COUNT_W-1:0] STOP_RESET    = COUNT_W'(MAX_BINS);
    localparam logic [COUNT_W-1:0] BINS_RESET    = COUNT_W'(MAX_BINS);
    localparam logic [COUNT_W-1:0] BINS_MAX      = COUNT_W'(MAX_BINS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_FRAMES  = 3'd0,
        REG_FEEDBACK_GAIN = 3'd1,
        REG_REVERB_MODE   = 3'd2,
        REG_STOP_BIN      = 3'd3,
        REG_BINS_IN_USE   = 3'd4
    } reg_index_t;

    typedef enum logic {
        MODE_CLASSIC   = 1'b0,
        MODE_RECURSIVE = 1'b1
    } reverb_mode_t;

    // per-bin stores share one address, so they live in one wide word
    typedef struct packed {
        logic [MAG_W-1:0]        saved_input;
        logic signed [RES_W-1:0] saved_output;
        logic signed [RES_W-1:0] smoothed_previous;
    } store_word_t;

    localparam int STORE_W = $bits(store_word_t);

endpackage

`default_nettype wire

// ===== design/smr_bin_if.sv =====
`default_nettype none

interface smr_bin_if;

    logic                         valid;
    logic                         ready;
    logic [smr_pkg::MAG_W-1:0]    magnitude;
    logic [smr_pkg::BIN_W-1:0]    bin_index;

    modport source (output valid, output magnitude, output bin_index, input ready);
    modport sink   (input valid, input magnitude, input bin_index, output ready);

endinterface

`default_nettype wire

// ===== design/smr_result_if.sv =====
`default_nettype none

interface smr_result_if;

    logic                                valid;
    logic                                ready;
    logic signed [smr_pkg::RES_W-1:0]    result_magnitude;
    logic [smr_pkg::BIN_W-1:0]           result_bin;
    logic                                frame_last;

    modport source (output valid, output result_magnitude, output result_bin,
                    output frame_last, input ready);
    modport sink   (input valid, input result_magnitude, input result_bin,
                    input frame_last, output ready);

endinterface

`default_nettype wire

// ===== design/smr_cfg_if.sv =====
`default_nettype none

interface smr_cfg_if;

    logic                              valid;
    logic                              ready;
    logic [smr_pkg::CFG_IDX_W-1:0]     index;
    logic [smr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

`default_nettype wire

// ===== design/smr_ram.sv =====
`default_nettype none

module smr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/spectral_magnitude_reverb_unit.sv =====
// Spectral magnitude reverb, one magnitude bin per request.
// Channels: spectrum (magnitude, bin_index) in, results (result_magnitude,
// result_bin, frame_last) out, both valid/ready; cfg writes one register
// (index, data) per request and is always ready. Write cfg only while idle.
// A bin_index of zero starts a frame and steps the frame counter; on frames
// where the counter is zero the per-bin stores are latched.
// An accepted request is registered in the compute stage, its result in the
// output register. Throughput: one request per cycle while results.ready is
// high, set by the single read port and single write port of the per-bin store
// RAM; a bin repeated in the next request uses a forwarding register.
// Reset: registers return to defaults, then a clearing pass writes zero to
// all 1024 store entries, one per cycle, with spectrum.ready held low; cfg
// writes are taken during the pass.
// Stall: the output register holds its result while results.ready is low;
// one more request may sit in the compute stage, after which spectrum.ready
// drops until the output drains.

`default_nettype none

module spectral_magnitude_reverb_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    smr_bin_if.sink            spectrum,
    smr_result_if.source       results,
    smr_cfg_if.sink            cfg
);

    localparam int PROD_W = smr_pkg::DIFF_W + smr_pkg::GAIN_W + 2;
    localparam int SUM_W  = smr_pkg::RES_W + 3;

    // configuration
    logic [smr_pkg::DELAY_W-1:0] delay_frames_reg;
    logic [smr_pkg::GAIN_W-1:0]  feedback_gain_reg;
    logic                        reverb_mode_reg;
    logic [smr_pkg::COUNT_W-1:0] stop_bin_reg;
    logic [smr_pkg::COUNT_W-1:0] bins_in_use_reg;

    // control
    logic                        clr_busy_reg;
    logic [smr_pkg::BIN_W-1:0]   clr_addr_reg;
    logic [smr_pkg::DELAY_W-1:0] frame_counter_reg;
    logic [smr_pkg::DELAY_W-1:0] frame_counter_next;
    logic                        s1_valid_reg;
    logic                        out_valid_reg;

    // compute stage payload
    logic [smr_pkg::MAG_W-1:0]   s1_mag_reg;
    logic [smr_pkg::BIN_W-1:0]   s1_bin_reg;
    logic                        s1_latch_reg;
    logic                        s1_in_frame_reg;
    logic                        s1_proc_reg;
    logic                        s1_last_reg;
    logic                        s1_fwd_reg;
    smr_pkg::store_word_t        s1_fwd_word_reg;

    // output payload
    logic signed [smr_pkg::RES_W-1:0] out_mag_reg;
    logic [smr_pkg::BIN_W-1:0]        out_bin_reg;
    logic                             out_last_reg;

    logic out_adv;
    logic s1_adv;
    logic accept;

    logic [smr_pkg::DELAY_W-1:0] fc_inc;
    logic [smr_pkg::DELAY_W-1:0] fc_wrapped;
    logic                        latch_in;
    logic [smr_pkg::COUNT_W-1:0] nb_eff;
    logic [smr_pkg::COUNT_W-1:0] bin_ext;
    logic                        in_frame_in;
    logic                        proc_in;
    logic                        last_in;

    logic [smr_pkg::STORE_W-1:0] ram_rd_data;
    logic                        ram_wr_en;
    logic [smr_pkg::BIN_W-1:0]   ram_wr_addr;
    logic [smr_pkg::STORE_W-1:0] ram_wr_data;

    smr_pkg::store_word_t               stored;
    smr_pkg::store_word_t               word_new;
    logic signed [smr_pkg::DIFF_W-1:0]  x_s;
    logic signed [smr_pkg::DIFF_W-1:0]  diff;
    logic [smr_pkg::GAIN_W-1:0]         gain_sat;
    logic signed [smr_pkg::GAIN_W+1:0]  gain_s;
    logic signed [PROD_W-1:0]           prod;
    logic signed [PROD_W-1:0]           rnd_full;
    logic signed [SUM_W-1:0]            sum;
    logic signed [smr_pkg::RES_W-1:0]   sat;
    logic signed [smr_pkg::RES_W-1:0]   y;
    logic                               s1_wr;

    assign cfg.ready = 1'b1;

    assign out_adv        = !out_valid_reg || results.ready;
    assign s1_adv         = s1_valid_reg && out_adv;
    assign spectrum.ready = !clr_busy_reg && (!s1_valid_reg || out_adv);
    assign accept         = spectrum.valid && spectrum.ready;

    // frame counter and per-bin classification at accept
    assign fc_inc     = frame_counter_reg + smr_pkg::DELAY_W'(1);
    assign fc_wrapped = (fc_inc >= delay_frames_reg) ? '0 : fc_inc;

    always_comb
    begin
        frame_counter_next = frame_counter_reg;
        if (spectrum.bin_index == '0)
        begin
            frame_counter_next = fc_wrapped;
        end
    end

    assign latch_in = (frame_counter_next == '0);

    always_comb
    begin
        if (bins_in_use_reg == '0)
        begin
            nb_eff = smr_pkg::COUNT_W'(1);
        end
        else if (bins_in_use_reg > smr_pkg::BINS_MAX)
        begin
            nb_eff = smr_pkg::BINS_MAX;
        end
        else
        begin
            nb_eff = bins_in_use_reg;
        end
    end

    assign bin_ext     = {1'b0, spectrum.bin_index};
    assign in_frame_in = bin_ext < nb_eff;
    assign proc_in     = bin_ext < stop_bin_reg;
    assign last_in     = in_frame_in && (bin_ext == nb_eff - smr_pkg::COUNT_W'(1));

    // compute stage
    assign stored = s1_fwd_reg ? s1_fwd_word_reg : smr_pkg::store_word_t'(ram_rd_data);
    assign x_s    = signed'({2'b00, s1_mag_reg});

    always_comb
    begin
        if (reverb_mode_reg == smr_pkg::MODE_RECURSIVE)
        begin
            diff = x_s - smr_pkg::DIFF_W'(stored.smoothed_previous);
        end
        else
        begin
            diff = smr_pkg::DIFF_W'(stored.saved_output) - x_s;
        end
    end

    assign gain_sat = (feedback_gain_reg > smr_pkg::GAIN_ONE) ? smr_pkg::GAIN_ONE
                                                               : feedback_gain_reg;
    assign gain_s   = signed'({2'b00, gain_sat});
    assign prod     = diff * gain_s;
    // round to nearest, ties up
    assign rnd_full = (prod + PROD_W'(16384)) >>> smr_pkg::FRAC_W;
    assign sum      = signed'({{(SUM_W-smr_pkg::MAG_W){1'b0}}, stored.saved_input})
                      + rnd_full[SUM_W-1:0];

    always_comb
    begin
        if (sum > SUM_W'(16777215))
        begin
            sat = smr_pkg::RES_W'(16777215);
        end
        else if (sum < -SUM_W'(16777216))
        begin
            sat = -smr_pkg::RES_W'(16777216);
        end
        else
        begin
            sat = sum[smr_pkg::RES_W-1:0];
        end
    end

    assign y = (s1_in_frame_reg && s1_proc_reg) ? sat : signed'({1'b0, s1_mag_reg});

    always_comb
    begin
        word_new = stored;
        if (s1_latch_reg)
        begin
            word_new.saved_input = s1_mag_reg;
        end
        if (reverb_mode_reg == smr_pkg::MODE_RECURSIVE)
        begin
            word_new.smoothed_previous = y;
        end
        else if (s1_latch_reg)
        begin
            word_new.saved_output = y;
        end
    end

    assign s1_wr = s1_adv && s1_in_frame_reg
                   && ((reverb_mode_reg == smr_pkg::MODE_RECURSIVE) || s1_latch_reg);

    // store RAM write port: clearing pass or compute stage
    assign ram_wr_en   = clr_busy_reg || s1_wr;
    assign ram_wr_addr = clr_busy_reg ? clr_addr_reg : s1_bin_reg;
    assign ram_wr_data = clr_busy_reg ? '0 : smr_pkg::STORE_W'(word_new);

    smr_ram #(
        .WIDTH (smr_pkg::STORE_W),
        .DEPTH (smr_pkg::MAX_BINS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (spectrum.bin_index),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_frames_reg  <= smr_pkg::DELAY_RESET;
            feedback_gain_reg <= smr_pkg::GAIN_RESET;
            reverb_mode_reg   <= smr_pkg::MODE_CLASSIC;
            stop_bin_reg      <= smr_pkg::STOP_RESET;
            bins_in_use_reg   <= smr_pkg::BINS_RESET;
            clr_busy_reg      <= 1'b1;
            clr_addr_reg      <= '0;
            frame_counter_reg <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (smr_pkg::reg_index_t'(cfg.index))
                    smr_pkg::REG_DELAY_FRAMES:
                        delay_frames_reg <= cfg.data[smr_pkg::DELAY_W-1:0];
                    smr_pkg::REG_FEEDBACK_GAIN:
                        feedback_gain_reg <= cfg.data[smr_pkg::GAIN_W-1:0];
                    smr_pkg::REG_REVERB_MODE:
                        reverb_mode_reg <= cfg.data[0];
                    smr_pkg::REG_STOP_BIN:
                        stop_bin_reg <= cfg.data[smr_pkg::COUNT_W-1:0];
                    smr_pkg::REG_BINS_IN_USE:
                        bins_in_use_reg <= cfg.data[smr_pkg::COUNT_W-1:0];
                    default:
                        ;
                endcase
            end

            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + smr_pkg::BIN_W'(1);
                if (clr_addr_reg == smr_pkg::BIN_W'(smr_pkg::MAX_BINS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            if (accept)
            begin
                frame_counter_reg <= frame_counter_next;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mag_reg      <= spectrum.magnitude;
            s1_bin_reg      <= spectrum.bin_index;
            s1_latch_reg    <= latch_in;
            s1_in_frame_reg <= in_frame_in;
            s1_proc_reg     <= proc_in;
            s1_last_reg     <= last_in;
            // same bin written by the stage ahead: RAM read returns stale data
            s1_fwd_reg      <= s1_wr && (s1_bin_reg == spectrum.bin_index);
            s1_fwd_word_reg <= word_new;
        end
        if (s1_adv)
        begin
            out_mag_reg  <= y;
            out_bin_reg  <= s1_bin_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.result_magnitude = out_mag_reg;
    assign results.result_bin       = out_bin_reg;
    assign results.frame_last       = out_last_reg;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smr_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 7;
    localparam int TIMEOUT_NS  = 10_000_000;
    localparam int MAX_PRINTED = 40;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;

    localparam longint MAG_HI   = (longint'(1) <<< (RES_W - 1)) - 1;
    localparam longint MAG_LO   = -(longint'(1) <<< (RES_W - 1));
    localparam longint HALF_LSB = longint'(1) <<< (FRAC_W - 1);

    typedef struct packed {
        logic signed [RES_W-1:0] magnitude;
        logic [BIN_W-1:0]        bin;
        logic                    last;
    } bin_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    smr_bin_if    bins_ch ();
    smr_result_if results_ch ();
    smr_cfg_if    cfg_ch ();

    spectral_magnitude_reverb_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .spectrum (bins_ch),
        .results  (results_ch),
        .cfg      (cfg_ch)
    );

    // shadow of the block's registers and per-bin stores
    logic [DELAY_W-1:0]      delay_frames_reg;
    logic [GAIN_W-1:0]       gain_reg;
    reverb_mode_t            mode_reg;
    logic [COUNT_W-1:0]      stop_bin_reg;
    logic [COUNT_W-1:0]      bins_reg;
    logic [DELAY_W-1:0]      frame_count;
    logic [MAG_W-1:0]        held_input  [MAX_BINS];
    logic signed [RES_W-1:0] held_output [MAX_BINS];
    logic signed [RES_W-1:0] smoothed    [MAX_BINS];

    bin_result_t pending_results [$];

    int mismatches = 0;
    int burst_left = 0;
    int burst_max  = 4;
    int gap_max    = 2;

    logic [15:0] stall_mask  = '0;
    logic [3:0]  stall_phase = '0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        results_ch.ready <= rst_n && !stall_mask[stall_phase];
        stall_phase      <= stall_phase + 1'b1;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t mismatch: %s", $time, what);
    endtask

    function automatic longint gain_term(input longint diff, input longint gain);
        return (diff * gain + HALF_LSB) >>> FRAC_W;
    endfunction

    function automatic logic signed [RES_W-1:0] clamp_magnitude(input longint v);
        if (v > MAG_HI)
            return RES_W'(MAG_HI);
        if (v < MAG_LO)
            return RES_W'(MAG_LO);
        return RES_W'(v);
    endfunction

    function automatic bin_result_t process_bin(input logic [MAG_W-1:0] mag,
                                                input logic [BIN_W-1:0] bin);
        bin_result_t r;
        longint      x;
        longint      gain;
        int          frame_bins;
        logic        latch;

        x          = longint'(mag);
        frame_bins = int'(bins_reg);
        if (frame_bins < 1)
            frame_bins = 1;
        if (frame_bins > MAX_BINS)
            frame_bins = MAX_BINS;
        gain = (gain_reg > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain_reg);

        if (bin == '0)
        begin
            frame_count = frame_count + 1'b1;
            if (frame_count >= delay_frames_reg)
                frame_count = '0;
        end

        r.magnitude = RES_W'(mag);
        r.bin       = bin;
        r.last      = 1'b0;

        if (int'(bin) < frame_bins)
        begin
            latch  = (frame_count == '0);
            r.last = (int'(bin) == frame_bins - 1);
            if (mode_reg == MODE_CLASSIC)
            begin
                if (bin < stop_bin_reg)
                    r.magnitude = clamp_magnitude(longint'(held_input[bin]) +
                        gain_term(longint'(held_output[bin]) - x, gain));
                if (latch)
                begin
                    held_input[bin]  = mag;
                    held_output[bin] = r.magnitude;
                end
            end
            else
            begin
                if (bin < stop_bin_reg)
                    r.magnitude = clamp_magnitude(longint'(held_input[bin]) +
                        gain_term(x - longint'(smoothed[bin]), gain));
                smoothed[bin] = r.magnitude;
                if (latch)
                    held_input[bin] = mag;
            end
        end
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] random_magnitude();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return MAG_W'($urandom_range(0, 255));
            default: return MAG_W'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin : check_results
        bin_result_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("bin %0d: result with nothing expected",
                                          results_ch.result_bin));
            else
            begin
                want = pending_results.pop_front();
                if (results_ch.result_magnitude !== want.magnitude)
                    report_mismatch($sformatf("bin %0d: magnitude %0d, expected %0d",
                        want.bin, results_ch.result_magnitude, want.magnitude));
                if (results_ch.result_bin !== want.bin)
                    report_mismatch($sformatf("result_bin %0d, expected %0d",
                        results_ch.result_bin, want.bin));
                if (results_ch.frame_last !== want.last)
                    report_mismatch($sformatf("bin %0d: frame_last %b, expected %b",
                        want.bin, results_ch.frame_last, want.last));
            end
        end
    end

    task automatic send_bin(input logic [MAG_W-1:0] mag, input logic [BIN_W-1:0] bin);
        int gap;
        bins_ch.valid     <= 1'b1;
        bins_ch.magnitude <= mag;
        bins_ch.bin_index <= bin;
        do
            @(posedge clk);
        while (!bins_ch.ready);
        pending_results.push_back(process_bin(mag, bin));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            gap        = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                bins_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        bins_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_DELAY_FRAMES:  delay_frames_reg = value[DELAY_W-1:0];
            REG_FEEDBACK_GAIN: gain_reg         = value[GAIN_W-1:0];
            REG_REVERB_MODE:   mode_reg         = reverb_mode_t'(value[0]);
            REG_STOP_BIN:      stop_bin_reg     = value[COUNT_W-1:0];
            REG_BINS_IN_USE:   bins_reg         = value[COUNT_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] delay,
                             input logic [CFG_DATA_W-1:0] gain,
                             input reverb_mode_t          mode,
                             input logic [CFG_DATA_W-1:0] stop,
                             input logic [CFG_DATA_W-1:0] frame_bins);
        write_reg(REG_DELAY_FRAMES, delay);
        write_reg(REG_FEEDBACK_GAIN, gain);
        write_reg(REG_REVERB_MODE, CFG_DATA_W'(mode));
        write_reg(REG_STOP_BIN, stop);
        write_reg(REG_BINS_IN_USE, frame_bins);
    endtask

    // gain above one, single-bin frame from zero, stop bin past the frame
    task automatic test_extreme_settings();
        configure(0, '1, MODE_CLASSIC, '1, 0);
        send_bin('1, 0);
        send_bin('0, 0);
        send_bin('1, 0);
        send_bin('1, 0);
        send_bin(1, '1);
        send_bin(3, 1);
        drain();
    endtask

    // oversized bin count clamps to the full frame; stop bin zero passes all
    task automatic test_wide_frame_recursive();
        configure(1, GAIN_ONE, MODE_RECURSIVE, 0, '1);
        send_bin('1, 0);
        send_bin('0, '1);
        send_bin(7, 512);
        drain();
        write_reg(REG_STOP_BIN, CFG_DATA_W'(STOP_RESET));
        send_bin('1, 0);
        send_bin('1, '1);
        drain();
    endtask

    // counter left above a lowered depth must wrap on the next frame start
    task automatic test_counter_past_depth();
        int i;
        configure(CFG_DATA_W'({DELAY_W{1'b1}}), GAIN_RESET, MODE_CLASSIC,
                  CFG_DATA_W'(STOP_RESET), 3);
        for (i = 1; i <= 4; i++)
            send_bin(MAG_W'(i * 1000), 0);
        drain();
        write_reg(REG_DELAY_FRAMES, 3);
        send_bin(MAG_W'(123456), 0);
        send_bin('1, 1);
        send_bin(MAG_W'(65536), 2);
        send_bin(MAG_W'(42), 3);
        drain();
    endtask

    // zero gain, stop bin inside the frame, write to an unmapped index
    task automatic test_partial_stop_band();
        configure(2, 0, MODE_RECURSIVE, 2, 4);
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_BINS_IN_USE) + 1,
                                            (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        send_bin('1, 0);
        send_bin('1, 1);
        send_bin('1, 2);
        send_bin(1, 3);
        drain();
    endtask

    task automatic test_random_frames();
        int                      phase;
        int                      sent;
        int                      k;
        int                      frame_bins;
        logic [CFG_DATA_W-1:0]   delay;
        logic [CFG_DATA_W-1:0]   gain;
        logic [CFG_DATA_W-1:0]   stop;
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            if (phase == 10)
                frame_bins = MAX_BINS;
            else if ($urandom_range(0, 3) == 0)
                frame_bins = $urandom_range(17, 64);
            else
                frame_bins = $urandom_range(1, 16);

            if (phase == 1)
                delay = 0;
            else if (phase == 2)
                delay = CFG_DATA_W'({DELAY_W{1'b1}});
            else if (phase == 5)
                delay = CFG_DATA_W'($urandom);
            else
                delay = CFG_DATA_W'($urandom_range(0, 6));

            if (phase == 0)
                gain = 0;
            else if (phase == 3)
                gain = GAIN_ONE;
            else if (phase == 4)
                gain = '1;
            else if ($urandom_range(0, 3) == 0)
                gain = CFG_DATA_W'($urandom);
            else
                gain = CFG_DATA_W'($urandom_range(0, int'(GAIN_ONE)));

            if ($urandom_range(0, 1) == 0)
                stop = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'(STOP_RESET) : '1;
            else
                stop = CFG_DATA_W'($urandom_range(0, frame_bins + 1));

            configure(delay, gain, (phase % 2 == 0) ? MODE_CLASSIC : MODE_RECURSIVE,
                      stop, CFG_DATA_W'(frame_bins));

            if (phase % 4 == 0)
            begin
                gap_max    = 0;
                burst_max  = 1;
                stall_mask = '0;
            end
            else
            begin
                gap_max    = $urandom_range(1, 6);
                burst_max  = $urandom_range(1, 8);
                stall_mask = 16'($urandom) & ~(16'(1) << $urandom_range(0, 15));
            end

            k    = 0;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_bin(random_magnitude(), BIN_W'($urandom));
                else
                begin
                    send_bin(random_magnitude(), BIN_W'(k));
                    k++;
                    if (k >= frame_bins || $urandom_range(0, 29) == 0)
                        k = 0;
                end
                sent++;
            end
        end
    endtask

    initial
    begin
        int i;
        bins_ch.valid     = 1'b0;
        bins_ch.magnitude = '0;
        bins_ch.bin_index = '0;
        results_ch.ready  = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;

        delay_frames_reg = DELAY_RESET;
        gain_reg         = GAIN_RESET;
        mode_reg         = MODE_CLASSIC;
        stop_bin_reg     = STOP_RESET;
        bins_reg         = BINS_RESET;
        frame_count      = '0;
        for (i = 0; i < MAX_BINS; i++)
        begin
            held_input[i]  = '0;
            held_output[i] = '0;
            smoothed[i]    = '0;
        end

        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;

        test_extreme_settings();
        test_wide_frame_recursive();
        test_counter_past_depth();
        test_partial_stop_band();
        test_random_frames();
        drain();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
